// ===== hdl/ptd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_pkg: shared definitions of the periodic task dispatcher
// Table size, derived widths, command and status codes, the slot entry
// record and the control word that the sequencer broadcasts to every cell.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_CREATE = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic KIND_DUE    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_INS,
    CELL_DEL
  } cell_op_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  task_id;
    logic [15:0] period;
    logic [7:0]  prio;
    logic [15:0] counter;
  } entry_t;

  typedef struct packed {
    cell_op_e         op;
    logic [7:0]       task_id;
    logic [15:0]      period;
    logic [7:0]       prio;
    logic [IDX_W-1:0] del_pos;
  } cell_ctl_t;

endpackage

// ===== hdl/ptd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_cell: one slot of the task table
// Holds one entry and, as the control word says, keeps it, takes the entry
// of its upper neighbor (rotate or close a gap), takes the entry of its lower
// neighbor (open a gap for an insert) or loads the new task.
// ----------------------------------------------------------------------------
module ptd_cell import ptd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic [IDX_W-1:0] idx_i,
  input  entry_t           prev_i,
  input  logic             prev_open_i,
  input  entry_t           next_i,
  output entry_t           entry_o,
  output logic             open_o
);

  logic        valid_q, valid_d;
  logic [7:0]  task_q, task_d;
  logic [15:0] period_q, period_d;
  logic [7:0]  prio_q, prio_d;
  logic [15:0] counter_q, counter_d;

  // A slot is open for an insert when it is empty or sorts after the new task.
  assign open_o = !valid_q || (prio_q > ctl_i.prio);

  assign entry_o = '{valid: valid_q, task_id: task_q, period: period_q,
                     prio: prio_q, counter: counter_q};

  always_comb begin
    valid_d   = valid_q;
    task_d    = task_q;
    period_d  = period_q;
    prio_d    = prio_q;
    counter_d = counter_q;
    unique case (ctl_i.op)
      CELL_HOLD: begin
      end
      CELL_ROT: begin
        valid_d   = next_i.valid;
        task_d    = next_i.task_id;
        period_d  = next_i.period;
        prio_d    = next_i.prio;
        counter_d = next_i.counter;
      end
      CELL_INS: begin
        if (prev_open_i) begin
          valid_d   = prev_i.valid;
          task_d    = prev_i.task_id;
          period_d  = prev_i.period;
          prio_d    = prev_i.prio;
          counter_d = prev_i.counter;
        end else if (open_o) begin
          valid_d   = 1'b1;
          task_d    = ctl_i.task_id;
          period_d  = ctl_i.period;
          prio_d    = ctl_i.prio;
          counter_d = '0;
        end
      end
      CELL_DEL: begin
        if (idx_i >= ctl_i.del_pos) begin
          valid_d   = next_i.valid;
          task_d    = next_i.task_id;
          period_d  = next_i.period;
          prio_d    = next_i.prio;
          counter_d = next_i.counter;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    task_q    <= task_d;
    period_q  <= period_d;
    prio_q    <= prio_d;
    counter_q <= counter_d;
  end

endmodule

// ===== hdl/periodic_task_dispatcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_dispatcher: priority-ordered table of periodic tasks
// A row of slot cells holds the sorted task table; a small sequencer drives
// all cells with one control word and sees the table through slot zero.
// ----------------------------------------------------------------------------
// The dispatcher takes one command word at a time and accepts a new one only
// when the previous command is fully handled. A create word inserts the task
// in place (every slot decides locally whether to keep its entry, take its
// lower neighbor's entry or load the new one) and its status word follows
// from the status state once the output register is free. A tick word
// rotates the whole ring of TASK_SLOTS slots once through slot zero, where a
// single incrementer and comparator bump each counter and spot due tasks;
// the rotation holds while a due word is blocked by the consumer, and a
// final flush state sends the last due word. Due words come out in table
// order and the final one carries last. A delete word first rotates the ring
// once to find the entry to remove (the last entry if it matches, otherwise
// the first match), then closes the gap and returns its status. The output
// register lets the consumer stall without losing words; an unused command
// code is dropped.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher import ptd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  task_id_i,
  input  logic [15:0] period_i,
  input  logic [7:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  due_task_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TICK   = 3'd1;
  localparam logic [2:0] S_TFLUSH = 3'd2;
  localparam logic [2:0] S_DSCAN  = 3'd3;
  localparam logic [2:0] S_DAPPLY = 3'd4;
  localparam logic [2:0] S_STAT   = 3'd5;

  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(TASK_SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TASK_SLOTS);

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pend_q, pend_d;
  logic [7:0]       pend_id_q, pend_id_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] first_q, first_d;
  logic             lhit_q, lhit_d;
  logic [1:0]       stat_q, stat_d;
  logic [7:0]       key_q, key_d;

  logic             out_valid_q;
  logic             kind_q;
  logic [7:0]       due_q;
  logic [1:0]       status_q;
  logic             last_q;

  logic             out_load;
  logic             out_kind_w;
  logic [7:0]       out_due_w;
  logic [1:0]       out_status_w;
  logic             out_last_w;

  cell_ctl_t        ctl;
  entry_t           cells   [TASK_SLOTS];
  logic             open_w  [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] valid_vec;
  entry_t           tail_w;

  logic             accept;
  logic             out_free;
  logic [CNT_W-1:0] last_idx;

  // Head unit: the entry in slot zero is the one the ring hands back to the
  // top slot, with its counter bumped, or cleared when due, during a tick.
  entry_t           head;
  logic [15:0]      head_inc;
  logic             head_due;
  logic             head_match;

  assign head       = cells[0];
  assign head_inc   = 16'(head.counter + 16'd1);
  assign head_due   = head.valid && (head_inc == head.period);
  assign head_match = head.valid && (head.task_id == key_q);

  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign last_idx   = CNT_W'(count_q - 1'b1);

  always_comb begin
    tail_w = head;
    if (state_q == S_TICK && head.valid) begin
      tail_w.counter = head_due ? 16'd0 : head_inc;
    end
    // Closing a gap pulls an empty entry into the top slot.
    if (ctl.op == CELL_DEL) begin
      tail_w.valid = 1'b0;
    end
  end

  // Slot cells. Each one sees its lower and upper neighbor only.
  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    entry_t prev_w;
    logic   prev_open_w;
    entry_t next_w;

    if (i == 0) begin : g_first
      assign prev_w      = '0;
      assign prev_open_w = 1'b0;
    end else begin : g_inner_prev
      assign prev_w      = cells[i-1];
      assign prev_open_w = open_w[i-1];
    end

    if (i == TASK_SLOTS - 1) begin : g_top
      assign next_w = tail_w;
    end else begin : g_inner_next
      assign next_w = cells[i+1];
    end

    ptd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .idx_i       (IDX_W'(i)),
      .prev_i      (prev_w),
      .prev_open_i (prev_open_w),
      .next_i      (next_w),
      .entry_o     (cells[i]),
      .open_o      (open_w[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    count_d      = count_q;
    pend_d       = pend_q;
    pend_id_d    = pend_id_q;
    found_d      = found_q;
    first_d      = first_q;
    lhit_d       = lhit_q;
    stat_d       = stat_q;
    key_d        = key_q;
    ctl.op       = CELL_HOLD;
    ctl.task_id  = task_id_i;
    ctl.period   = period_i;
    ctl.prio     = priority_req_i;
    ctl.del_pos  = '0;
    out_load     = 1'b0;
    out_kind_w   = KIND_DUE;
    out_due_w    = 8'd0;
    out_status_w = ST_OK;
    out_last_w   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action_i)
            ACT_TICK: begin
              step_d  = '0;
              pend_d  = 1'b0;
              state_d = S_TICK;
            end
            ACT_CREATE: begin
              if (count_q == SLOTS_CNT) begin
                stat_d = ST_FULL;
              end else begin
                ctl.op  = CELL_INS;
                count_d = CNT_W'(count_q + 1'b1);
                stat_d  = ST_OK;
              end
              state_d = S_STAT;
            end
            ACT_DELETE: begin
              key_d   = task_id_i;
              step_d  = '0;
              found_d = 1'b0;
              lhit_d  = 1'b0;
              state_d = S_DSCAN;
            end
            default: begin
            end
          endcase
        end
      end

      S_TICK: begin
        // A due task waits in the pending register until the next one is
        // found, so that the final due word can be flagged last.
        if (!(head_due && pend_q && !out_free)) begin
          ctl.op = CELL_ROT;
          if (head_due) begin
            if (pend_q) begin
              out_load   = 1'b1;
              out_kind_w = KIND_DUE;
              out_due_w  = pend_id_q;
              out_last_w = 1'b0;
            end
            pend_d    = 1'b1;
            pend_id_d = head.task_id;
          end
          step_d = CNT_W'(step_q + 1'b1);
          if (step_q == STEP_LAST) begin
            state_d = S_TFLUSH;
          end
        end
      end

      S_TFLUSH: begin
        if (!pend_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_kind_w = KIND_DUE;
          out_due_w  = pend_id_q;
          out_last_w = 1'b1;
          pend_d     = 1'b0;
          state_d    = S_IDLE;
        end
      end

      S_DSCAN: begin
        ctl.op = CELL_ROT;
        if (head_match && !found_q) begin
          found_d = 1'b1;
          first_d = IDX_W'(step_q);
        end
        if (head.valid && step_q == last_idx) begin
          lhit_d = head_match;
        end
        step_d = CNT_W'(step_q + 1'b1);
        if (step_q == STEP_LAST) begin
          state_d = S_DAPPLY;
        end
      end

      S_DAPPLY: begin
        if (lhit_q) begin
          ctl.op      = CELL_DEL;
          ctl.del_pos = IDX_W'(last_idx);
          count_d     = last_idx;
          stat_d      = ST_OK;
        end else if (found_q) begin
          ctl.op      = CELL_DEL;
          ctl.del_pos = first_q;
          count_d     = last_idx;
          stat_d      = ST_OK;
        end else begin
          stat_d = ST_NOT_FOUND;
        end
        state_d = S_STAT;
      end

      S_STAT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_w   = KIND_STATUS;
          out_due_w    = 8'd0;
          out_status_w = stat_q;
          out_last_w   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      lhit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      lhit_q  <= lhit_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    first_q   <= first_d;
    stat_q    <= stat_d;
    key_q     <= key_d;
    if (out_load) begin
      kind_q   <= out_kind_w;
      due_q    <= out_due_w;
      status_q <= out_status_w;
      last_q   <= out_last_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign due_task_o  = due_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  // The entry count never exceeds the table size.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SLOTS_CNT)
    else $error("entry count beyond table size");

  // Between commands the valid slots match the entry count.
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(valid_vec) == int'(count_q)))
    else $error("valid slots disagree with entry count");

  // An accepted tick always starts the rotation.
  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == ACT_TICK) |=> (state_q == S_TICK))
    else $error("tick did not start rotation");

  // A pending due task exists only while a tick is being handled.
  a_pend_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_TICK || state_q == S_TFLUSH))
    else $error("pending due task outside a tick");

endmodule

// ===== tb/periodic_task_dispatcher_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_checker: predicting monitor of the task dispatcher
// Watches both word channels, keeps its own copy of the task table, works
// out the words that each accepted command must produce and compares every
// produced word with the oldest one still awaited.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_checker import ptd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  task_id_i,
  input  logic [15:0] period_i,
  input  logic [7:0]  priority_req_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        kind_i,
  input  logic [7:0]  due_task_i,
  input  logic [1:0]  status_i,
  input  logic        last_i,
  output int          error_count_o,
  output int          pending_o
);

  typedef struct {
    logic       kind;
    logic [7:0] due_task;
    logic [1:0] status;
    logic       last;
  } dispatch_word_t;

  dispatch_word_t awaited_words[$];

  // Shadow copy of the sorted task table.
  logic [7:0]  slot_task[TASK_SLOTS];
  logic [15:0] slot_period[TASK_SLOTS];
  logic [7:0]  slot_prio[TASK_SLOTS];
  logic [15:0] slot_counter[TASK_SLOTS];
  int          slot_count;

  initial begin
    error_count_o = 0;
    pending_o     = 0;
    slot_count    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: dispatcher mismatch: %s", $realtime, what);
    error_count_o++;
  endtask

  task automatic push_word(input logic kind, input logic [7:0] due,
                           input logic [1:0] status, input logic last);
    dispatch_word_t w;
    w.kind     = kind;
    w.due_task = due;
    w.status   = status;
    w.last     = last;
    awaited_words.push_back(w);
  endtask

  task automatic copy_slot(input int dst, input int src);
    slot_task[dst]    = slot_task[src];
    slot_period[dst]  = slot_period[src];
    slot_prio[dst]    = slot_prio[src];
    slot_counter[dst] = slot_counter[src];
  endtask

  // Applies one accepted command to the shadow table and queues its words.
  task automatic apply_command(input logic [1:0] act, input logic [7:0] id,
                               input logic [15:0] per, input logic [7:0] prio);
    int             pos;
    int             fired;
    logic [1:0]     st;
    dispatch_word_t w;
    fired = 0;
    pos   = 0;
    case (act)
      ACT_TICK: begin
        for (int i = 0; i < slot_count; i++) slot_counter[i] = slot_counter[i] + 16'd1;
        for (int i = 0; i < slot_count; i++) begin
          if (slot_counter[i] == slot_period[i]) begin
            slot_counter[i] = '0;
            push_word(KIND_DUE, slot_task[i], ST_OK, 1'b0);
            fired++;
          end
        end
        if (fired > 0) begin
          w = awaited_words.pop_back();
          w.last = 1'b1;
          awaited_words.push_back(w);
        end
      end
      ACT_CREATE: begin
        if (slot_count >= TASK_SLOTS) begin
          st = ST_FULL;
        end else begin
          while (pos < slot_count && slot_prio[pos] <= prio) pos++;
          for (int i = slot_count; i > pos; i--) copy_slot(i, i - 1);
          slot_task[pos]    = id;
          slot_period[pos]  = per;
          slot_prio[pos]    = prio;
          slot_counter[pos] = '0;
          slot_count++;
          st = ST_OK;
        end
        push_word(KIND_STATUS, 8'd0, st, 1'b1);
      end
      ACT_DELETE: begin
        st = ST_NOT_FOUND;
        if (slot_count > 0) begin
          if (slot_task[slot_count - 1] == id) begin
            slot_count--;
            st = ST_OK;
          end else begin
            while (pos < slot_count && slot_task[pos] != id) pos++;
            if (pos < slot_count) begin
              for (int i = pos; i + 1 < slot_count; i++) copy_slot(i, i + 1);
              slot_count--;
              st = ST_OK;
            end
          end
        end
        push_word(KIND_STATUS, 8'd0, st, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dispatch_word_t w;
    if (!rst_ni) begin
      slot_count = 0;
      awaited_words.delete();
    end else begin
      // A word leaving the block can never stem from a command taken at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (awaited_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind=%0d due=%0d status=%0d last=%0d",
                                    kind_i, due_task_i, status_i, last_i));
        end else begin
          w = awaited_words.pop_front();
          if (kind_i !== w.kind)
            report_mismatch($sformatf("kind %0d, awaited %0d", kind_i, w.kind));
          if (due_task_i !== w.due_task)
            report_mismatch($sformatf("due_task %0d, awaited %0d", due_task_i, w.due_task));
          if (status_i !== w.status)
            report_mismatch($sformatf("status %0d, awaited %0d", status_i, w.status));
          if (last_i !== w.last)
            report_mismatch($sformatf("last %0d, awaited %0d", last_i, w.last));
        end
      end
      if (in_valid_i && in_ready_i)
        apply_command(action_i, task_id_i, period_i, priority_req_i);
    end
    pending_o = awaited_words.size();
  end

endmodule

// ===== tb/periodic_task_dispatcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_test: stimulus and verdict for the task dispatcher
// Drives a directed run through the table corner cases followed by random
// create, delete and tick commands, with random gaps on both channels and one
// long consumer hold-off. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_test;
  import ptd_pkg::*;

  // The command code that the dispatcher silently drops.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int RANDOM_WORDS   = 180;
  localparam int HOLD_CYCLES    = 300;
  // Longest stretch without any accepted word in a correct run is the
  // consumer hold-off plus one full ring rotation; this is many times that.
  localparam int STALL_LIMIT    = 4000;
  localparam int IDLE_PERCENT   = 13;
  localparam int CALM_FIRST     = 60;
  localparam int CALM_LAST      = 110;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [1:0]  action         = ACT_TICK;
  logic [7:0]  task_id        = '0;
  logic [15:0] period         = '0;
  logic [7:0]  priority_req   = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic        kind;
  logic [7:0]  due_task;
  logic [1:0]  status;
  logic        last;
  int          error_count;
  int          pending;

  // Shared between the producer and consumer processes.
  bit          calm           = 1'b0;
  bit          hold_pending   = 1'b0;

  periodic_task_dispatcher uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .task_id_i      (task_id),
    .period_i       (period),
    .priority_req_i (priority_req),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .due_task_o     (due_task),
    .status_o       (status),
    .last_o         (last)
  );

  periodic_task_dispatcher_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .action_i       (action),
    .task_id_i      (task_id),
    .period_i       (period),
    .priority_req_i (priority_req),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .kind_i         (kind),
    .due_task_i     (due_task),
    .status_i       (status),
    .last_i         (last),
    .error_count_o  (error_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offers one command word. Called at a falling edge and returns at the
  // falling edge after the word was taken, so valid is assigned exactly once
  // per falling edge and stays high across back-to-back words.
  task automatic send_word(input logic [1:0] act, input logic [7:0] id,
                           input logic [15:0] per, input logic [7:0] prio);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    action       <= act;
    task_id      <= id;
    period       <= per;
    priority_req <= prio;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // Consumer: random back-pressure, none during the calm window, and one
  // long hold-off on request so that the output register and then the
  // command input both stall while the producer keeps offering words.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: any run that goes too long without a handshake is a failure.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int          pick;
    logic [1:0]  act;
    logic [7:0]  id;
    logic [15:0] per;
    logic [7:0]  prio;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Empty-table cases first: a delete that finds nothing,
    // a tick with nothing due and the dropped command code.
    send_word(ACT_DELETE, 8'd0, 16'd0, 8'd0);
    send_word(ACT_TICK, 8'hFF, 16'hFFFF, 8'hFF);
    send_word(ACT_UNUSED, 8'hA5, 16'h5A5A, 8'h3C);
    // Fill the table: field extremes, a period of zero that only fires after
    // the counter wraps, equal priorities that must keep arrival order and a
    // duplicate identifier.
    send_word(ACT_CREATE, 8'hFF, 16'hFFFF, 8'hFF);
    send_word(ACT_CREATE, 8'd0, 16'd0, 8'd0);
    send_word(ACT_CREATE, 8'd1, 16'd1, 8'd5);
    send_word(ACT_CREATE, 8'd2, 16'd2, 8'd5);
    send_word(ACT_CREATE, 8'd3, 16'd1, 8'd5);
    send_word(ACT_CREATE, 8'd1, 16'd3, 8'd0);
    send_word(ACT_CREATE, 8'd4, 16'd2, 8'hFF);
    send_word(ACT_CREATE, 8'd5, 16'd1, 8'd128);
    // The table is full now, so this one is rejected.
    send_word(ACT_CREATE, 8'd6, 16'd1, 8'd1);
    // Ticks with several due tasks per tick, reported in table order.
    repeat (3) send_word(ACT_TICK, 8'd0, 16'd0, 8'd0);
    // Delete the last entry, then the first of two entries sharing an
    // identifier, then an identifier that is not there.
    send_word(ACT_DELETE, 8'd4, 16'd0, 8'd0);
    send_word(ACT_DELETE, 8'd1, 16'd0, 8'd0);
    send_word(ACT_DELETE, 8'd77, 16'd0, 8'd0);
    repeat (2) send_word(ACT_TICK, 8'd0, 16'd0, 8'd0);
    send_word(ACT_DELETE, 8'hFF, 16'd0, 8'd0);
    send_word(ACT_TICK, 8'd0, 16'd0, 8'd0);

    // Random part. Identifiers, periods and priorities mostly come from
    // small ranges so that deletes hit, tasks fall due often and priorities
    // tie; now and then the full range exercises every field bit.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      if (n == 20) hold_pending = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 2) act = ACT_UNUSED;
      else if (pick < 55) act = ACT_TICK;
      else if (pick < 80) act = ACT_CREATE;
      else act = ACT_DELETE;
      id   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 9));
      per  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(1, 4));
      prio = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 3));
      send_word(act, id, per, prio);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain: every awaited word must arrive, then give a trailing tick time
    // to finish its rotation and expose any stray word.
    while (pending != 0) @(posedge clk_i);
    repeat (TASK_SLOTS + 6) @(posedge clk_i);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
